/* design/extendible_hash_directory_defines.svh */
// Assertion macros shared by the directory design.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef EXTENDIBLE_HASH_DIRECTORY_DEFINES_SVH
`define EXTENDIBLE_HASH_DIRECTORY_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EHD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EHD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ehd_pkg.sv */
`default_nettype none
package ehd_pkg;

  localparam int OP_W    = 2;
  localparam int IDX_W   = 10;
  localparam int DEPTH_W = 6;
  localparam int SEG_W   = 20;
  localparam int ST_W    = 2;

  localparam logic [OP_W-1:0] OP_READ   = 2'd0;
  localparam logic [OP_W-1:0] OP_EXPAND = 2'd1;
  localparam logic [OP_W-1:0] OP_SPLIT  = 2'd2;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_MISMATCH = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE    = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [IDX_W-1:0]   entry_index;
    logic [DEPTH_W-1:0] target_depth;
    logic [SEG_W-1:0]   low_segment;
    logic [SEG_W-1:0]   high_segment;
    logic [DEPTH_W-1:0] split_depth;
  } item_t;

  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic [SEG_W-1:0]   entry_segment;
    logic [DEPTH_W-1:0] entry_depth;
    logic [DEPTH_W-1:0] current_global_depth;
  } result_t;

endpackage
`default_nettype wire

/* design/ehd_if.sv */
`default_nettype none
interface ehd_in_if;
  import ehd_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [IDX_W-1:0]   entry_index;
  logic [DEPTH_W-1:0] target_depth;
  logic [SEG_W-1:0]   low_segment;
  logic [SEG_W-1:0]   high_segment;
  logic [DEPTH_W-1:0] split_depth;

  modport source (
    output valid, operation, entry_index, target_depth, low_segment, high_segment,
    split_depth,
    input  ready
  );
  modport sink (
    input  valid, operation, entry_index, target_depth, low_segment, high_segment,
    split_depth,
    output ready
  );
endinterface

interface ehd_out_if;
  import ehd_pkg::*;

  logic               valid;
  logic               ready;
  logic [ST_W-1:0]    status;
  logic [SEG_W-1:0]   entry_segment;
  logic [DEPTH_W-1:0] entry_depth;
  logic [DEPTH_W-1:0] current_global_depth;

  modport source (
    output valid, status, entry_segment, entry_depth, current_global_depth,
    input  ready
  );
  modport sink (
    input  valid, status, entry_segment, entry_depth, current_global_depth,
    output ready
  );
endinterface
`default_nettype wire

/* design/ehd_ram.sv */
`default_nettype none
module ehd_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* design/ehd_seq.sv */
`default_nettype none
module ehd_seq #(
  parameter int GROUP_BITS     = 4,
  parameter int DIR_INDEX_BITS = 10,
  parameter int SEG_ID_BITS    = 20
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ehd_pkg::item_t  in_item,
  output logic            res_valid,
  input  logic            res_take,
  output ehd_pkg::result_t res_item
);
  import ehd_pkg::*;
  `include "extendible_hash_directory_defines.svh"

  localparam int IW = DIR_INDEX_BITS;
  localparam int SW = SEG_ID_BITS;
  localparam int DW = DEPTH_W + SW;
  localparam logic [DEPTH_W-1:0] GB_D  = DEPTH_W'(GROUP_BITS);
  localparam logic [DEPTH_W-1:0] MAX_D = DEPTH_W'(GROUP_BITS + DIR_INDEX_BITS);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_READ     = 3'd1;
  localparam logic [2:0] S_EXP      = 3'd2;
  localparam logic [2:0] S_EXP_LAST = 3'd3;
  localparam logic [2:0] S_SPL_CHK  = 3'd4;
  localparam logic [2:0] S_SPL_WR   = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  function automatic logic [IW-1:0] low_mask(input logic [DEPTH_W-1:0] n);
    logic [IW:0] t;
    t = ({{IW{1'b0}}, 1'b1} << n) - {{IW{1'b0}}, 1'b1};
    return t[IW-1:0];
  endfunction

  function automatic result_t make_res(input logic [ST_W-1:0] st,
                                       input logic [SEG_W-1:0] seg,
                                       input logic [DEPTH_W-1:0] dep,
                                       input logic [DEPTH_W-1:0] gd);
    result_t r;
    r.status               = st;
    r.entry_segment        = seg;
    r.entry_depth          = dep;
    r.current_global_depth = gd;
    return r;
  endfunction

  logic [2:0]         state_r, state_nxt;
  logic [DEPTH_W-1:0] gd_r, gd_nxt;
  logic [IW-1:0]      live_r, live_nxt;
  logic               wpend_r, wpend_nxt;
  logic               e0_wr_r, e0_wr_nxt;
  logic               ovr_r, ovr_nxt;

  logic [DEPTH_W-1:0] target_r, target_nxt;
  logic [DEPTH_W-1:0] diff_r, diff_nxt;
  logic [DEPTH_W-1:0] ldep_r, ldep_nxt;
  logic [IW-1:0]      cnt_r, cnt_nxt;
  logic [IW-1:0]      wd_r, wd_nxt;
  logic [IW-1:0]      base_r, base_nxt;
  logic [IW-1:0]      span_r, span_nxt;
  logic [SW-1:0]      lo_r, lo_nxt;
  logic [SW-1:0]      hi_r, hi_nxt;
  result_t            res_r, res_nxt;

  logic               ram_we, ram_re;
  logic [IW-1:0]      ram_waddr, ram_raddr;
  logic [DW-1:0]      ram_wdata, ram_rdata;

  logic               in_fire;
  logic [IW+IDX_W-1:0] idx_ext;
  logic [IW-1:0]      idx_w;
  logic [SW+SEG_W-1:0] lo_ext, hi_ext, rd_seg_ext;
  logic [DEPTH_W-1:0] split_sh;
  logic [IW-1:0]      split_span, split_base, half_bit;
  logic [DW-1:0]      rd_data_fix;
  logic [SW-1:0]      rd_seg;
  logic [DEPTH_W-1:0] rd_dep;

  ehd_ram #(
    .WIDTH (DW),
    .DEPTH (1 << DIR_INDEX_BITS)
  ) u_dir_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign res_valid = (state_r == S_DONE);
  assign res_item  = res_r;

  assign idx_ext = {{IW{1'b0}}, in_item.entry_index};
  assign idx_w   = idx_ext[IW-1:0];
  assign lo_ext  = {{SW{1'b0}}, in_item.low_segment};
  assign hi_ext  = {{SW{1'b0}}, in_item.high_segment};

  assign split_sh   = gd_r - in_item.split_depth;
  assign split_span = low_mask(split_sh);
  assign split_base = idx_w & live_r & ~split_span;
  assign half_bit   = span_r & ~(span_r >> 1);

  // Entry 0 holds its reset contents until the first write reaches it.
  assign rd_data_fix = ovr_r ? {GB_D, {SW{1'b0}}} : ram_rdata;
  assign rd_seg      = rd_data_fix[SW-1:0];
  assign rd_dep      = rd_data_fix[DW-1:SW];
  assign rd_seg_ext  = {{SEG_W{1'b0}}, rd_seg};

  always_comb begin
    state_nxt  = state_r;
    gd_nxt     = gd_r;
    live_nxt   = live_r;
    wpend_nxt  = wpend_r;
    target_nxt = target_r;
    diff_nxt   = diff_r;
    ldep_nxt   = ldep_r;
    cnt_nxt    = cnt_r;
    wd_nxt     = wd_r;
    base_nxt   = base_r;
    span_nxt   = span_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    res_nxt    = res_r;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          wpend_nxt  = 1'b0;
          target_nxt = in_item.target_depth;
          ldep_nxt   = in_item.split_depth;
          lo_nxt     = lo_ext[SW-1:0];
          hi_nxt     = hi_ext[SW-1:0];
          unique case (in_item.operation)
            OP_READ: begin
              ram_re    = 1'b1;
              ram_raddr = idx_w & live_r;
              state_nxt = S_READ;
            end
            OP_EXPAND: begin
              if (in_item.target_depth < gd_r || in_item.target_depth > MAX_D) begin
                res_nxt   = make_res(ST_RANGE, '0, '0, gd_r);
                state_nxt = S_DONE;
              end else if (in_item.target_depth == gd_r) begin
                res_nxt   = make_res(ST_OK, '0, '0, gd_r);
                state_nxt = S_DONE;
              end else begin
                diff_nxt  = in_item.target_depth - gd_r;
                cnt_nxt   = low_mask(in_item.target_depth - GB_D);
                state_nxt = S_EXP;
              end
            end
            OP_SPLIT: begin
              if (in_item.split_depth >= gd_r || in_item.split_depth < GB_D) begin
                res_nxt   = make_res(ST_RANGE, '0, '0, gd_r);
                state_nxt = S_DONE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = split_base;
                base_nxt  = split_base;
                span_nxt  = split_span;
                state_nxt = S_SPL_CHK;
              end
            end
            default: begin
              res_nxt   = make_res(ST_RANGE, '0, '0, gd_r);
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        res_nxt   = make_res(ST_OK, rd_seg_ext[SEG_W-1:0], rd_dep, gd_r);
        state_nxt = S_DONE;
      end
      S_EXP: begin
        ram_re    = 1'b1;
        ram_raddr = cnt_r >> diff_r;
        ram_we    = wpend_r;
        ram_waddr = wd_r;
        ram_wdata = rd_data_fix;
        wd_nxt    = cnt_r;
        wpend_nxt = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_EXP_LAST;
        end else begin
          cnt_nxt = cnt_r - {{(IW-1){1'b0}}, 1'b1};
        end
      end
      S_EXP_LAST: begin
        ram_we    = 1'b1;
        ram_waddr = wd_r;
        ram_wdata = rd_data_fix;
        gd_nxt    = target_r;
        live_nxt  = low_mask(target_r - GB_D);
        res_nxt   = make_res(ST_OK, '0, '0, target_r);
        state_nxt = S_DONE;
      end
      S_SPL_CHK: begin
        if (rd_dep != ldep_r) begin
          res_nxt   = make_res(ST_MISMATCH, '0, '0, gd_r);
          state_nxt = S_DONE;
        end else begin
          cnt_nxt   = '0;
          state_nxt = S_SPL_WR;
        end
      end
      S_SPL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = base_r | cnt_r;
        ram_wdata = {ldep_r + DEPTH_W'(1), ((cnt_r & half_bit) != '0) ? hi_r : lo_r};
        if (cnt_r == span_r) begin
          res_nxt   = make_res(ST_OK, '0, '0, gd_r);
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + {{(IW-1){1'b0}}, 1'b1};
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign e0_wr_nxt = e0_wr_r || (ram_we && ram_waddr == '0);
  assign ovr_nxt   = ram_re && ram_raddr == '0 && !e0_wr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      gd_r    <= GB_D;
      live_r  <= '0;
      wpend_r <= 1'b0;
      e0_wr_r <= 1'b0;
      ovr_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      gd_r    <= gd_nxt;
      live_r  <= live_nxt;
      wpend_r <= wpend_nxt;
      e0_wr_r <= e0_wr_nxt;
      ovr_r   <= ovr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    target_r <= target_nxt;
    diff_r   <= diff_nxt;
    ldep_r   <= ldep_nxt;
    cnt_r    <= cnt_nxt;
    wd_r     <= wd_nxt;
    base_r   <= base_nxt;
    span_r   <= span_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    res_r    <= res_nxt;
  end

  `EHD_ASSERT_NOW(a_gd_range, 1'b1, (gd_r >= GB_D && gd_r <= MAX_D), "global depth out of range")
  `EHD_ASSERT_NOW(a_we_state, ram_we, (state_r == S_EXP || state_r == S_EXP_LAST || state_r == S_SPL_WR), "directory write outside a walk")
  `EHD_ASSERT_NOW(a_split_addr, (state_r == S_SPL_WR), ((ram_waddr & ~span_r) == base_r), "split write left its range")
  `EHD_ASSERT_NOW(a_exp_order, (state_r == S_EXP && wpend_r), (ram_raddr < ram_waddr), "expand source overwritten before read")
  `EHD_ASSERT_NEXT(a_busy_after_accept, in_fire, (state_r != S_IDLE), "item accepted without leaving idle")

endmodule
`default_nettype wire

/* design/extendible_hash_directory.sv */
// Extendible-hashing directory. The directory lives in one memory of
// 2^DIR_INDEX_BITS entries, each a segment id and a local depth, with one write
// and one registered read per cycle; the global depth is a register. One item is
// handled at a time. A read fetches its entry from the memory and registers it
// as the result. An expand walks the live directory top-down, one entry per
// cycle through the memory port; an expand to the current depth or an
// out-of-range request goes straight to the result. A split checks the first
// entry of the segment's range and then writes the range one entry per cycle.
// After reset, entry 0 holds segment 0 at local depth GROUP_BITS, the other
// entries are unwritten, and no clearing pass is needed. A finished result
// waits in an output register while the next item is accepted.
`default_nettype none
module extendible_hash_directory #(
  parameter int GROUP_BITS     = 4,
  parameter int DIR_INDEX_BITS = 10,
  parameter int SEG_ID_BITS    = 20
) (
  input  logic       clk,
  input  logic       rst_n,
  ehd_in_if.sink     in_ch,
  ehd_out_if.source  out_ch
);
  import ehd_pkg::*;

  item_t   in_item;
  result_t res_item;
  result_t out_item_r, out_item_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    res_valid, res_take;

  assign in_item.operation    = in_ch.operation;
  assign in_item.entry_index  = in_ch.entry_index;
  assign in_item.target_depth = in_ch.target_depth;
  assign in_item.low_segment  = in_ch.low_segment;
  assign in_item.high_segment = in_ch.high_segment;
  assign in_item.split_depth  = in_ch.split_depth;

  ehd_seq #(
    .GROUP_BITS     (GROUP_BITS),
    .DIR_INDEX_BITS (DIR_INDEX_BITS),
    .SEG_ID_BITS    (SEG_ID_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res_item  (res_item)
  );

  assign res_take      = !out_valid_r || out_ch.ready;
  assign out_valid_nxt = (res_valid && res_take) || (out_valid_r && !out_ch.ready);
  assign out_item_nxt  = (res_valid && res_take) ? res_item : out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_ch.valid                = out_valid_r;
  assign out_ch.status               = out_item_r.status;
  assign out_ch.entry_segment        = out_item_r.entry_segment;
  assign out_ch.entry_depth          = out_item_r.entry_depth;
  assign out_ch.current_global_depth = out_item_r.current_global_depth;

endmodule
`default_nettype wire

/* test/ehd_directory_checker.sv */
`timescale 1ns / 1ps
module ehd_directory_checker #(
  parameter int GROUP_BITS     = 4,
  parameter int DIR_INDEX_BITS = 10
) (
  input  logic clk,
  input  logic rst_n,
  ehd_in_if    in_ch,
  ehd_out_if   out_ch,
  output int   fail_count,
  output int   outstanding
);
  import ehd_pkg::*;

  localparam int DIR_ENTRIES = 1 << DIR_INDEX_BITS;
  localparam int MAX_GLOBAL  = GROUP_BITS + DIR_INDEX_BITS;

  logic [SEG_W-1:0]   seg_mem   [0:DIR_ENTRIES-1];
  logic [DEPTH_W-1:0] depth_mem [0:DIR_ENTRIES-1];
  int                 global_depth;
  result_t            awaited_results [$];
  int                 fails;

  initial begin
    for (int i = 0; i < DIR_ENTRIES; i++) begin
      seg_mem[i]   = '0;
      depth_mem[i] = '0;
    end
    depth_mem[0] = DEPTH_W'(GROUP_BITS);
    global_depth = GROUP_BITS;
    fails        = 0;
    fail_count   = 0;
    outstanding  = 0;
  end

  function automatic result_t apply_directory_op(item_t it);
    result_t r;
    int      live;
    int      diff;
    int      span;
    int      half;
    int      base;
    int      tgt;
    int      sd;
    r        = '0;
    r.status = ST_RANGE;
    live     = 1 << (global_depth - GROUP_BITS);
    case (it.operation)
      OP_READ: begin
        base            = int'(it.entry_index) & (live - 1);
        r.status        = ST_OK;
        r.entry_segment = seg_mem[base];
        r.entry_depth   = depth_mem[base];
      end
      OP_EXPAND: begin
        tgt = int'(it.target_depth);
        if (tgt >= global_depth && tgt <= MAX_GLOBAL) begin
          diff = tgt - global_depth;
          for (int j = (1 << (tgt - GROUP_BITS)) - 1; j >= 0; j--) begin
            seg_mem[j]   = seg_mem[j >> diff];
            depth_mem[j] = depth_mem[j >> diff];
          end
          global_depth = tgt;
          r.status     = ST_OK;
        end
      end
      OP_SPLIT: begin
        sd = int'(it.split_depth);
        if (sd < global_depth && sd >= GROUP_BITS) begin
          span = 1 << (global_depth - sd);
          half = span >> 1;
          base = int'(it.entry_index) & (live - 1) & ~(span - 1);
          if (int'(depth_mem[base]) != sd) begin
            r.status = ST_MISMATCH;
          end else begin
            for (int k = 0; k < half; k++) begin
              seg_mem[base + k]          = it.low_segment;
              depth_mem[base + k]        = DEPTH_W'(sd + 1);
              seg_mem[base + half + k]   = it.high_segment;
              depth_mem[base + half + k] = DEPTH_W'(sd + 1);
            end
            r.status = ST_OK;
          end
        end
      end
      default: begin
      end
    endcase
    r.current_global_depth = DEPTH_W'(global_depth);
    return r;
  endfunction

  always @(posedge clk) begin
    item_t   seen;
    result_t got;
    result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        seen.operation    = in_ch.operation;
        seen.entry_index  = in_ch.entry_index;
        seen.target_depth = in_ch.target_depth;
        seen.low_segment  = in_ch.low_segment;
        seen.high_segment = in_ch.high_segment;
        seen.split_depth  = in_ch.split_depth;
        awaited_results.push_back(apply_directory_op(seen));
      end
      if (out_ch.valid && out_ch.ready) begin
        got.status               = out_ch.status;
        got.entry_segment        = out_ch.entry_segment;
        got.entry_depth          = out_ch.entry_depth;
        got.current_global_depth = out_ch.current_global_depth;
        if (awaited_results.size() == 0) begin
          $error("result arrived with no item pending: status %0d", got.status);
          fails++;
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            fails++;
          end
          if (got.entry_segment !== want.entry_segment) begin
            $error("entry_segment expected %0h actual %0h",
                   want.entry_segment, got.entry_segment);
            fails++;
          end
          if (got.entry_depth !== want.entry_depth) begin
            $error("entry_depth expected %0d actual %0d", want.entry_depth, got.entry_depth);
            fails++;
          end
          if (got.current_global_depth !== want.current_global_depth) begin
            $error("current_global_depth expected %0d actual %0d",
                   want.current_global_depth, got.current_global_depth);
            fails++;
          end
        end
      end
      fail_count  <= fails;
      outstanding <= awaited_results.size();
    end
  end

endmodule

/* test/tb_extendible_hash_directory.sv */
`timescale 1ns / 1ps
module tb_extendible_hash_directory;
  import ehd_pkg::*;

  localparam int GROUP_BITS     = 4;
  localparam int DIR_INDEX_BITS = 10;
  localparam int SEG_ID_BITS    = 20;
  localparam int DIR_ENTRIES    = 1 << DIR_INDEX_BITS;
  localparam int MAX_GLOBAL     = GROUP_BITS + DIR_INDEX_BITS;
  localparam int RANDOM_ITEMS   = 1150;
  localparam int IDLE_LIMIT     = 20000;
  localparam int DRAIN_CYCLES   = 1100;

  logic clk = 1'b0;
  logic rst_n;

  ehd_in_if  in_ch ();
  ehd_out_if out_ch ();

  int fail_count;
  int outstanding;
  int idle_cycles = 0;
  int burst_left  = 0;

  logic [DEPTH_W-1:0] lane_depth [0:DIR_ENTRIES-1];
  int                 stim_gdepth;

  extendible_hash_directory #(
    .GROUP_BITS     (GROUP_BITS),
    .DIR_INDEX_BITS (DIR_INDEX_BITS),
    .SEG_ID_BITS    (SEG_ID_BITS)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ehd_directory_checker #(
    .GROUP_BITS     (GROUP_BITS),
    .DIR_INDEX_BITS (DIR_INDEX_BITS)
  ) u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [15:0] stall_pattern;
    int          phase;
    stall_pattern = 16'hFFFF;
    phase         = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (phase == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          stall_pattern = 16'hFFFF;
        end else begin
          stall_pattern = 16'($urandom) | 16'h0001;
        end
      end
      out_ch.ready <= stall_pattern[phase];
      phase = (phase + 1) % 16;
    end
  end

  function automatic item_t mk(logic [OP_W-1:0] op, int idx, int tgt, int lo, int hi, int sd);
    item_t it;
    it.operation    = op;
    it.entry_index  = IDX_W'(idx);
    it.target_depth = DEPTH_W'(tgt);
    it.low_segment  = SEG_W'(lo);
    it.high_segment = SEG_W'(hi);
    it.split_depth  = DEPTH_W'(sd);
    return it;
  endfunction

  // Local depths are mirrored here only to steer splits toward ones that succeed.
  function automatic void track_item(item_t it);
    int live;
    int tgt;
    int sd;
    int diff;
    int span;
    int base;
    live = 1 << (stim_gdepth - GROUP_BITS);
    tgt  = int'(it.target_depth);
    sd   = int'(it.split_depth);
    if (it.operation == OP_EXPAND && tgt >= stim_gdepth && tgt <= MAX_GLOBAL) begin
      diff = tgt - stim_gdepth;
      for (int j = (1 << (tgt - GROUP_BITS)) - 1; j >= 0; j--) begin
        lane_depth[j] = lane_depth[j >> diff];
      end
      stim_gdepth = tgt;
    end else if (it.operation == OP_SPLIT && sd < stim_gdepth && sd >= GROUP_BITS) begin
      span = 1 << (stim_gdepth - sd);
      base = int'(it.entry_index) & (live - 1) & ~(span - 1);
      if (int'(lane_depth[base]) == sd) begin
        for (int k = 0; k < span; k++) begin
          lane_depth[base + k] = DEPTH_W'(sd + 1);
        end
      end
    end
  endfunction

  function automatic item_t next_random_item(int cap);
    item_t it;
    int    live;
    int    ld;
    int    pick;
    int    tgt;
    it   = mk(OP_READ, $urandom_range(0, 1023), $urandom_range(0, 63),
              $urandom_range(0, 20'hFFFFF), $urandom_range(0, 20'hFFFFF),
              $urandom_range(0, 63));
    live = 1 << (stim_gdepth - GROUP_BITS);
    ld   = int'(lane_depth[int'(it.entry_index) & (live - 1)]);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      it.operation = OP_READ;
    end else if (pick < 80) begin
      if (ld < stim_gdepth) begin
        it.operation   = OP_SPLIT;
        it.split_depth = DEPTH_W'(ld);
        if ((1 << (stim_gdepth - ld)) > 128 && $urandom_range(0, 7) != 0) begin
          it.operation = OP_READ;
        end
      end else if (stim_gdepth < cap) begin
        it.operation    = OP_EXPAND;
        it.target_depth = DEPTH_W'(stim_gdepth + 1);
      end else begin
        it.operation = OP_READ;
      end
    end else if (pick < 90) begin
      tgt = stim_gdepth + $urandom_range(0, 2);
      if (tgt > cap) begin
        tgt = stim_gdepth;
      end
      it.operation    = OP_EXPAND;
      it.target_depth = DEPTH_W'(tgt);
    end else begin
      it.operation = OP_W'($urandom_range(0, 3));
      tgt          = int'(it.target_depth);
      if (it.operation == OP_EXPAND && tgt > cap && tgt <= MAX_GLOBAL) begin
        it.target_depth = DEPTH_W'(stim_gdepth);
      end
    end
    return it;
  endfunction

  task automatic issue(input item_t it);
    int gap;
    track_item(it);
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.operation    <= it.operation;
    in_ch.entry_index  <= it.entry_index;
    in_ch.target_depth <= it.target_depth;
    in_ch.low_segment  <= it.low_segment;
    in_ch.high_segment <= it.high_segment;
    in_ch.split_depth  <= it.split_depth;
    in_ch.valid        <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  initial begin
    int cap;
    for (int i = 0; i < DIR_ENTRIES; i++) begin
      lane_depth[i] = '0;
    end
    lane_depth[0] = DEPTH_W'(GROUP_BITS);
    stim_gdepth   = GROUP_BITS;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.operation    <= OP_READ;
    in_ch.entry_index  <= '0;
    in_ch.target_depth <= '0;
    in_ch.low_segment  <= '0;
    in_ch.high_segment <= '0;
    in_ch.split_depth  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    issue(mk(OP_READ, 0, 0, 0, 0, 0));
    issue(mk(OP_READ, 1023, 63, 20'hFFFFF, 20'hFFFFF, 63));
    issue(mk(OP_SPLIT, 0, 0, 1, 2, 4));
    issue(mk(OP_EXPAND, 0, 3, 0, 0, 0));
    issue(mk(OP_EXPAND, 0, 4, 0, 0, 0));
    issue(mk(OP_EXPAND, 0, 63, 0, 0, 0));
    issue(mk(OP_EXPAND, 0, 15, 0, 0, 0));
    issue(mk(OP_EXPAND, 0, 6, 0, 0, 0));
    issue(mk(OP_SPLIT, 3, 0, 20'hFFFFF, 0, 4));
    issue(mk(OP_SPLIT, 0, 0, 5, 6, 3));
    issue(mk(OP_SPLIT, 0, 0, 5, 6, 63));
    issue(mk(OP_SPLIT, 0, 0, 5, 6, 4));
    issue(mk(OP_SPLIT, 1023, 0, 20'h12345, 20'hABCDE, 5));
    issue(mk(OP_READ, 2, 0, 0, 0, 0));
    issue(mk(OP_READ, 1023, 0, 0, 0, 0));
    issue(mk(OP_READ, 0, 0, 0, 0, 0));
    issue(mk(OP_READ, 1, 0, 0, 0, 0));
    issue(mk(2'd3, 1023, 63, 20'hFFFFF, 20'hFFFFF, 63));
    issue(mk(OP_SPLIT, 1, 0, 0, 20'hFFFFF, 5));
    issue(mk(OP_READ, 0, 0, 0, 0, 0));
    issue(mk(OP_READ, 1, 0, 0, 0, 0));
    issue(mk(OP_EXPAND, 0, 7, 0, 0, 0));
    issue(mk(OP_READ, 7, 0, 0, 0, 0));
    issue(mk(OP_READ, 6, 0, 0, 0, 0));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      cap = GROUP_BITS + (n * (DIR_INDEX_BITS + 1)) / RANDOM_ITEMS;
      if (cap > MAX_GLOBAL) begin
        cap = MAX_GLOBAL;
      end
      issue(next_random_item(cap));
    end
    in_ch.valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
